// ===== hdl/atq_pkg.sv =====
// atq_pkg: shared types, codes and constants of the affinity task queue
// no dependencies; used by the interfaces, the queue and the checker
`default_nettype none

package atq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int NUM_CORES       = 8;

    localparam int CMD_W  = 2;
    localparam int MASK_W = 8;
    localparam int CORE_W = 3;
    localparam int STAT_W = 2;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_ENQ       = 2'd0;
    localparam t_cmd CMD_DEQ_FIRST = 2'd1;
    localparam t_cmd CMD_DEQ_NAMED = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REPLY
    } t_state;

    // one-hot bit of a core; a core outside the configured set has no bit
    function automatic logic [MASK_W-1:0] core_bit(input logic [CORE_W-1:0] core);
        logic [MASK_W-1:0] bits;
        bits = '0;
        if (int'(core) < NUM_CORES) begin
            bits = MASK_W'(1) << core;
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/atq_if.sv =====
// atq_cmd_if / atq_rsp_if: valid-ready channels for commands and responses
// depends on atq_pkg for field widths and default handle width
`default_nettype none

interface atq_cmd_if #(
    parameter int HANDLE_BITS = atq_pkg::HANDLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [atq_pkg::CMD_W-1:0]     cmd;
    logic [HANDLE_BITS-1:0]        task_handle;
    logic [atq_pkg::MASK_W-1:0]    affinity_mask;
    logic [atq_pkg::CORE_W-1:0]    core_id;

    modport source (output valid, cmd, task_handle, affinity_mask, core_id, input ready);
    modport sink   (input valid, cmd, task_handle, affinity_mask, core_id, output ready);
endinterface

interface atq_rsp_if #(
    parameter int HANDLE_BITS = atq_pkg::HANDLE_BITS_DEF,
    parameter int OCC_BITS    = $clog2(atq_pkg::QUEUE_DEPTH_DEF + 1)
);
    logic                          valid;
    logic                          ready;
    logic [atq_pkg::STAT_W-1:0]    status;
    logic [HANDLE_BITS-1:0]        out_handle;
    logic [OCC_BITS-1:0]           occupancy;

    modport source (output valid, status, out_handle, occupancy, input ready);
    modport sink   (input valid, status, out_handle, occupancy, output ready);
endinterface

`default_nettype wire

// ===== hdl/atq_mem.sv =====
// atq_mem: entry store, one write port and one registered read port
// no package dependency; instantiated by affinity_task_queue
`default_nettype none

module atq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/affinity_task_queue.sv =====
// affinity_task_queue: ordered task queue with per-core affinity, top level
// depends on atq_pkg, atq_cmd_if, atq_rsp_if and atq_mem
//
// Queue of task handles, oldest first, each held with an 8-bit affinity mask (zero: any
// core). One command is worked on at a time. A dequeue walks the entry memory from the
// oldest entry, reading each entry checked and then comparing it, and on a hit closes
// the gap by moving each younger entry up one place, with a read and then a write per
// entry moved; on an empty queue it replies without a walk. The walk follows from the
// single, registered read port of the entry memory. A response sits in an output
// register, so the next command is taken while the last response still waits. No
// clearing pass is needed after reset.
`default_nettype none

module affinity_task_queue #(
    parameter int QUEUE_DEPTH = atq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = atq_pkg::HANDLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    atq_cmd_if.sink    i_cmd,
    atq_rsp_if.source  o_rsp
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int MASK_W = atq_pkg::MASK_W;
    localparam int ENT_W  = HANDLE_BITS + MASK_W;

    // control state
    atq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_out_valid;

    // working copy of the command and its result
    atq_pkg::t_cmd          r_cmd, n_cmd;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [MASK_W-1:0]      r_core_bit, n_core_bit;
    atq_pkg::t_status       r_status, n_status;
    logic [HANDLE_BITS-1:0] r_res, n_res;

    // response register
    atq_pkg::t_status       r_out_status;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [CW-1:0]          r_out_occ;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    logic                   in_xfer;
    logic                   load_out;
    logic [HANDLE_BITS-1:0] ent_handle;
    logic [MASK_W-1:0]      ent_mask;
    logic                   ent_elig;
    logic                   name_match;
    logic                   hit;
    logic                   blocked;
    logic                   more;

    atq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cmd.ready = (r_state == atq_pkg::S_IDLE);
    assign in_xfer     = i_cmd.valid && i_cmd.ready;

    // entry under test, valid in S_SCAN_CHK
    assign ent_handle = mem_rdata[ENT_W-1:MASK_W];
    assign ent_mask   = mem_rdata[MASK_W-1:0];
    assign ent_elig   = (ent_mask == '0) || ((ent_mask & r_core_bit) != '0);
    assign name_match = (r_cmd == atq_pkg::CMD_DEQ_NAMED) && (ent_handle == r_handle);
    assign hit        = ent_elig && ((r_cmd == atq_pkg::CMD_DEQ_FIRST) || name_match);
    // oldest entry with the handle is not eligible: search ends here
    assign blocked    = name_match && !ent_elig;
    // another entry follows the current index (count already reduced while shifting)
    assign more       = (CW'(r_idx) + CW'(1)) < r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            atq_pkg::S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_cmd.cmd)
                        atq_pkg::CMD_DEQ_FIRST, atq_pkg::CMD_DEQ_NAMED: begin
                            n_state = (r_count == '0) ? atq_pkg::S_REPLY : atq_pkg::S_SCAN_RD;
                        end
                        default: begin
                            n_state = atq_pkg::S_REPLY;
                        end
                    endcase
                end
            end
            atq_pkg::S_SCAN_RD: begin
                n_state = atq_pkg::S_SCAN_CHK;
            end
            atq_pkg::S_SCAN_CHK: begin
                if (hit) begin
                    n_state = more ? atq_pkg::S_SHIFT_RD : atq_pkg::S_REPLY;
                end else if (blocked || !more) begin
                    n_state = atq_pkg::S_REPLY;
                end else begin
                    n_state = atq_pkg::S_SCAN_RD;
                end
            end
            atq_pkg::S_SHIFT_RD: begin
                n_state = atq_pkg::S_SHIFT_WR;
            end
            atq_pkg::S_SHIFT_WR: begin
                n_state = more ? atq_pkg::S_SHIFT_RD : atq_pkg::S_REPLY;
            end
            atq_pkg::S_REPLY: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = atq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = atq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_handle   = r_handle;
        n_core_bit = r_core_bit;
        n_status   = r_status;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = mem_rdata;
        mem_raddr  = r_idx;
        load_out   = 1'b0;
        unique case (r_state)
            atq_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_cmd      = i_cmd.cmd;
                    n_handle   = i_cmd.task_handle;
                    n_core_bit = atq_pkg::core_bit(i_cmd.core_id);
                    n_idx      = '0;
                    n_res      = '0;
                    n_status   = atq_pkg::ST_NONE;
                    if (i_cmd.cmd == atq_pkg::CMD_ENQ) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = atq_pkg::ST_FULL;
                        end else begin
                            // append at the young end
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = {i_cmd.task_handle, i_cmd.affinity_mask};
                            n_count   = r_count + CW'(1);
                            n_status  = atq_pkg::ST_OK;
                        end
                    end
                end
            end
            atq_pkg::S_SCAN_RD: begin
                mem_raddr = r_idx;
            end
            atq_pkg::S_SCAN_CHK: begin
                if (hit) begin
                    n_res    = ent_handle;
                    n_status = atq_pkg::ST_OK;
                    n_count  = r_count - CW'(1);
                end else if (!blocked && more) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            atq_pkg::S_SHIFT_RD: begin
                mem_raddr = r_idx + AW'(1);
            end
            atq_pkg::S_SHIFT_WR: begin
                // read and write never overlap, so no forwarding is needed
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                if (more) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            atq_pkg::S_REPLY: begin
                load_out = !r_out_valid || o_rsp.ready;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_handle   <= n_handle;
        r_core_bit <= n_core_bit;
        r_status   <= n_status;
        r_res      <= n_res;
        if (load_out) begin
            r_out_status <= r_status;
            r_out_handle <= r_res;
            r_out_occ    <= r_count;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_handle = r_out_handle;
    assign o_rsp.occupancy  = r_out_occ;

endmodule

`default_nettype wire

// ===== hdl/atq_chk.sv =====
// atq_chk: port-level checks of affinity_task_queue, with its bind statement
// depends on atq_pkg for status codes
`default_nettype none

module atq_chk #(
    parameter int QUEUE_DEPTH = atq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = atq_pkg::HANDLE_BITS_DEF,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [atq_pkg::STAT_W-1:0] i_status,
    input wire logic [HANDLE_BITS-1:0]    i_out_handle,
    input wire logic [CW-1:0]             i_occupancy
);

    // one command in flight: a transfer is never followed directly by another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command taken while the previous one is still in work");

    // a refused enqueue only happens on a full queue and returns no handle
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == atq_pkg::ST_FULL)) |->
            ((i_occupancy == CW'(QUEUE_DEPTH)) && (i_out_handle == '0)))
        else $error("full status without a full queue or with a handle");

    // a failed dequeue returns no handle
    a_none_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == atq_pkg::ST_NONE)) |-> (i_out_handle == '0))
        else $error("failed dequeue returned a handle");

    // occupancy never exceeds the queue depth
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_occupancy <= CW'(QUEUE_DEPTH)))
        else $error("occupancy beyond queue depth");

    // a response held back keeps its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_out_handle) && $stable(i_occupancy)))
        else $error("stalled response changed");

endmodule

bind affinity_task_queue atq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
) u_atq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_out_handle (o_rsp.out_handle),
    .i_occupancy  (o_rsp.occupancy)
);

`default_nettype wire
